// ----- src/sit_pkg.sv -----
// Package for the shortest interval tracker.
// Holds field widths, constants, the controller state type and the command
// and status structs shared by the controller and the datapath.
package sit_pkg;

  localparam int unsigned TickW      = 32;
  localparam int unsigned NoteW      = 7;
  localparam int unsigned IntervalW  = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 80;
  localparam int unsigned MaxNotesDef = 64;

  localparam logic [TickW-1:0]  RestartAvg   = 32'd50000;
  localparam logic [CountW-1:0] RestartCount = 8'd1;
  localparam logic [CountW-1:0] CountMax     = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_start;
    logic load_avg;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic joins;
    logic div_done;
  } status_t;

endpackage

// ----- src/sit_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no package dependency.
module sit_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sit_divider.sv -----
// Radix-2 restoring divider: 32-bit unsigned dividend by 8-bit divisor.
// One quotient bit per cycle; uses widths from sit_pkg.
module sit_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sit_pkg::TickW-1:0]  dividend_i,
  input  logic [sit_pkg::CountW-1:0] divisor_i,
  output logic                       done_o,
  output logic [sit_pkg::TickW-1:0]  quotient_o
);
  import sit_pkg::*;

  localparam int unsigned CntW = $clog2(TickW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TickW-1:0]  quo_q, quo_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] div_q, div_d;
  logic [CountW:0]   rem_sh;
  logic [CountW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[TickW-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sub[CountW-1:0];
        quo_d = {quo_q[TickW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CountW-1:0];
        quo_d = {quo_q[TickW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(TickW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/sit_datapath.sv -----
// Datapath of the shortest interval tracker: input and state registers,
// interval and near tests, the divider, the interval RAM and output registers.
// Depends on sit_pkg, sit_divider and sit_ram.
module sit_datapath #(
  parameter int unsigned MaxNotes = sit_pkg::MaxNotesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sit_pkg::cmd_t                cmd_i,
  output sit_pkg::status_t             status_o,
  input  logic [sit_pkg::InDataW-1:0]  in_data_i,
  output logic [sit_pkg::OutDataW-1:0] out_data_o
);
  import sit_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxNotes);
  localparam int unsigned SlotW = (AddrW > NoteW) ? AddrW : NoteW;

  logic [TickW-1:0]     now_q;
  logic [NoteW-1:0]     note_q;
  logic [TickW-1:0]     last_tick_q, last_tick_d;
  logic [CountW-1:0]    short_count_q, short_count_d;
  logic [TickW-1:0]     short_sum_q, short_sum_d;
  logic [TickW-1:0]     avg_q, avg_d;
  logic [TickW-1:0]     total_q, total_d;
  logic [IntervalW-1:0] iv16_q, iv16_d;
  logic [OutDataW-1:0]  out_q;

  logic                 restart;
  logic [TickW-1:0]     diff;
  logic [IntervalW-1:0] iv16;
  logic [TickW-1:0]     iv;
  logic [TickW-1:0]     iv_diff;
  logic [TickW-1:0]     iv_plus_half;
  logic [TickW-1:0]     avg_plus_half;
  logic                 below;
  logic                 near_low;
  logic                 near_high;
  logic                 joins;
  logic                 clear;
  logic [CountW-1:0]    count_base;
  logic [TickW-1:0]     sum_base;
  logic [SlotW-1:0]     slot;
  logic                 slot_ok;
  logic                 ram_we;
  logic                 div_done;
  logic [TickW-1:0]     quotient;

  assign restart       = (note_q == '0);
  assign diff          = now_q - last_tick_q;
  assign iv16          = diff[IntervalW-1:0];
  assign iv            = {{(TickW - IntervalW){iv16[IntervalW-1]}}, iv16};
  assign iv_diff       = iv - avg_q;
  assign iv_plus_half  = iv + {iv[TickW-1], iv[TickW-1:1]};
  assign avg_plus_half = avg_q + {1'b0, avg_q[TickW-1:1]};
  assign below         = iv_diff[TickW-1];
  assign near_low      = below && (iv_plus_half < avg_q);
  assign near_high     = avg_plus_half > iv;
  assign joins         = below || near_high;
  assign clear         = near_low;
  assign count_base    = clear ? '0 : short_count_q;
  assign sum_base      = clear ? '0 : short_sum_q;

  assign slot    = SlotW'(note_q) - 1'b1;
  assign slot_ok = ({1'b0, slot} < (SlotW + 1)'(MaxNotes));
  assign ram_we  = cmd_i.eval && !restart && slot_ok;

  always_comb begin
    last_tick_d   = last_tick_q;
    short_count_d = short_count_q;
    short_sum_d   = short_sum_q;
    avg_d         = avg_q;
    total_d       = total_q;
    iv16_d        = iv16_q;
    if (cmd_i.eval) begin
      last_tick_d = now_q;
      if (restart) begin
        total_d       = '0;
        avg_d         = RestartAvg;
        short_count_d = RestartCount;
        iv16_d        = '0;
      end else begin
        iv16_d  = iv16;
        total_d = total_q + iv;
        if (joins) begin
          short_count_d = (count_base < CountMax) ? count_base + 1'b1 : count_base;
          short_sum_d   = sum_base + iv;
        end
      end
    end
    if (cmd_i.load_avg) begin
      avg_d = quotient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tick_q   <= '0;
      short_count_q <= '0;
      short_sum_q   <= '0;
      avg_q         <= '0;
      total_q       <= '0;
    end else begin
      last_tick_q   <= last_tick_d;
      short_count_q <= short_count_d;
      short_sum_q   <= short_sum_d;
      avg_q         <= avg_d;
      total_q       <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iv16_q <= iv16_d;
    if (cmd_i.load_in) begin
      now_q  <= in_data_i[TickW-1:0];
      note_q <= in_data_i[TickW +: NoteW];
    end
    if (cmd_i.load_out) begin
      out_q <= {total_q, avg_q, iv16_q};
    end
  end

  sit_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (short_sum_q),
    .divisor_i  (short_count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  sit_ram #(
    .Width (IntervalW),
    .Depth (MaxNotes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot[AddrW-1:0]),
    .wdata_i (iv16),
    .re_i    (1'b0),
    .raddr_i (slot[AddrW-1:0]),
    .rdata_o ()
  );

  assign status_o.restart  = restart;
  assign status_o.joins    = joins;
  assign status_o.div_done = div_done;
  assign out_data_o        = out_q;

endmodule

// ----- src/sit_ctrl.sv -----
// Controller of the shortest interval tracker: evaluates each event, divides
// when the interval joins, and owns both stream handshakes. Depends on sit_pkg.
module sit_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output sit_pkg::cmd_t    cmd_o,
  input  sit_pkg::status_t status_i
);
  import sit_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_tready_i;
    cmd_o       = '0;
    s_tready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.load_in = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!status_i.restart && status_i.joins) begin
          state_d = ST_DIV_START;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.load_avg = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

// ----- src/shortest_interval_tracker.sv -----
// Shortest interval tracker top level: joins the controller and the datapath.
// Depends on sit_pkg, sit_ctrl and sit_datapath.
//
// Usage: each input transaction on the s_axis channel is one note event,
// carrying the tick count and the number of notes recorded so far. Each event
// gives exactly one output transaction on the m_axis channel with the
// interval since the previous event, the current shortest average and the
// total recording time. A note number of zero restarts the recording.
// Timing: for a restart or an interval that does not join the average, the
// result is registered through the evaluation and finish states; when the
// interval joins, the bit-serial divider that forms the new average runs
// between them. One event is processed at a time, so a new event is not
// accepted until the previous one reaches the output register. The output
// register lets a new event be accepted while the previous result still
// waits; a stalled receiver holds its result stable and holds the following
// result back in the datapath until it is taken.
// Reset clears all tracking state and the output valid flag; the interval
// store holds no defined contents until written.
module shortest_interval_tracker #(
  parameter int unsigned MaxNotes = sit_pkg::MaxNotesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0: now_tick[31:0], note_number[38:32], zero pad[39].
  input  logic [sit_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0: interval[15:0], shortest_average[47:16],
  // total_time[79:48].
  output logic [sit_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import sit_pkg::*;

  cmd_t    cmd;
  status_t status;

  sit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  sit_datapath #(
    .MaxNotes (MaxNotes)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule
